FILE: design/ccs_pkg.sv
// Package for the curvature cosine similarity block.
// Holds field widths, request and register codes, state types and the result struct.
// No dependencies; every other design file depends on it.
package ccs_pkg;

  localparam int BINS_DEF    = 50;
  localparam int COUNT_W_DEF = 10;

  localparam int REQ_W   = 2;
  localparam int TIME_W  = 16;
  localparam int SIM_W   = 17;
  localparam int DOT_W   = 32;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [REQ_W-1:0] REQ_SPIKE_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SPIKE_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  localparam logic REG_BIN_WIDTH = 1'b0;

  localparam logic [TIME_W-1:0] BIN_WIDTH_RESET = 16'd256;

  localparam int DIV_STEPS  = 16;
  localparam int QUO_W      = 31;
  localparam int SQRT_STEPS = 16;

  localparam logic [31:0]       SQRT_ONE_INIT = 32'h4000_0000;
  localparam logic [SIM_W-1:0]  SIM_HALF      = 17'd32768;
  localparam logic signed [DOT_W-1:0] DOT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DOT_W-1:0] DOT_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_RD, ST_WR, ST_MAC, ST_SOLVE, ST_EMIT
  } ccs_state_e;

  typedef enum logic [2:0] {
    MS_IDLE, MS_READ, MS_DIFF, MS_SQA, MS_SQB, MS_CROSS, MS_ACC
  } mac_state_e;

  typedef enum logic [2:0] {
    SV_IDLE, SV_MULP, SV_MULS, SV_DIV, SV_SQRT, SV_DONE
  } solve_state_e;

  typedef struct packed {
    logic [SIM_W-1:0]        similarity;
    logic                    degenerate;
    logic signed [DOT_W-1:0] dot_product;
  } ccs_result_t;

endpackage

FILE: design/ccs_if.sv
// Request and result channel interfaces of the curvature cosine similarity block.
// Depends on ccs_pkg for the field widths.
interface ccs_req_if;
  logic                        valid;
  logic                        ready;
  logic [ccs_pkg::REQ_W-1:0]   req_type;
  logic [ccs_pkg::TIME_W-1:0]  spike_time;

  modport source (output valid, req_type, spike_time, input ready);
  modport sink   (input valid, req_type, spike_time, output ready);
endinterface

interface ccs_res_if;
  logic                              valid;
  logic                              ready;
  logic [ccs_pkg::SIM_W-1:0]         similarity;
  logic                              degenerate;
  logic signed [ccs_pkg::DOT_W-1:0]  dot_product;

  modport source (output valid, similarity, degenerate, dot_product, input ready);
  modport sink   (input valid, similarity, degenerate, dot_product, output ready);
endinterface

FILE: design/ccs_hist.sv
// Two histogram memories with one registered read port and one write port.
// Per-entry valid bits make unwritten or cleared entries read as zero.
// Depends on ccs_pkg.
module ccs_hist #(
  parameter int BINS        = ccs_pkg::BINS_DEF,
  parameter int COUNT_WIDTH = ccs_pkg::COUNT_W_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [$clog2(BINS)-1:0]     rd_addr_i,
  output logic [COUNT_WIDTH-1:0]      rd_a_o,
  output logic [COUNT_WIDTH-1:0]      rd_b_o,
  input  logic                        wr_en_i,
  input  logic                        wr_sel_i,
  input  logic [$clog2(BINS)-1:0]     wr_addr_i,
  input  logic [COUNT_WIDTH-1:0]      wr_data_i,
  input  logic                        clr_i
);
  import ccs_pkg::*;

  logic [COUNT_WIDTH-1:0] mem_a [BINS];
  logic [COUNT_WIDTH-1:0] mem_b [BINS];
  logic [BINS-1:0]        valid_a_q, valid_b_q;
  logic [COUNT_WIDTH-1:0] data_a_q, data_b_q;
  logic                   rv_a_q, rv_b_q;

  always_ff @(posedge clk_i) begin
    data_a_q <= mem_a[rd_addr_i];
    data_b_q <= mem_b[rd_addr_i];
    if (wr_en_i && !wr_sel_i) begin
      mem_a[wr_addr_i] <= wr_data_i;
    end
    if (wr_en_i && wr_sel_i) begin
      mem_b[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= '0;
      valid_b_q <= '0;
      rv_a_q    <= 1'b0;
      rv_b_q    <= 1'b0;
    end else begin
      rv_a_q <= valid_a_q[rd_addr_i];
      rv_b_q <= valid_b_q[rd_addr_i];
      if (clr_i) begin
        valid_a_q <= '0;
        valid_b_q <= '0;
      end else if (wr_en_i) begin
        if (wr_sel_i) begin
          valid_b_q[wr_addr_i] <= 1'b1;
        end else begin
          valid_a_q[wr_addr_i] <= 1'b1;
        end
      end
    end
  end

  assign rd_a_o = rv_a_q ? data_a_q : '0;
  assign rd_b_o = rv_b_q ? data_b_q : '0;

endmodule

FILE: design/ccs_bindiv.sv
// Restoring divider that turns a spike time into a bin index, one quotient bit per cycle.
// Depends on ccs_pkg.
module ccs_bindiv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ccs_pkg::TIME_W-1:0]  num_i,
  input  logic [ccs_pkg::TIME_W-1:0]  den_i,
  output logic                        done_o,
  output logic [ccs_pkg::TIME_W-1:0]  quo_o
);
  import ccs_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TIME_W-1:0] rem_q, quo_q, den_q;
  logic [TIME_W:0]   shifted, diff;

  assign shifted = {rem_q, quo_q[TIME_W-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[TIME_W]) begin
        rem_q <= diff[TIME_W-1:0];
        quo_q <= {quo_q[TIME_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[TIME_W-1:0];
        quo_q <= {quo_q[TIME_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: design/ccs_mac.sv
// Sweeps both histograms and accumulates the curvature dot product and squared norms.
// One signed multiplier is shared by the three products of each bin.
// Depends on ccs_pkg.
module ccs_mac #(
  parameter int BINS        = ccs_pkg::BINS_DEF,
  parameter int COUNT_WIDTH = ccs_pkg::COUNT_W_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              start_i,
  output logic [$clog2(BINS)-1:0]                           rd_addr_o,
  input  logic [COUNT_WIDTH-1:0]                            rd_a_i,
  input  logic [COUNT_WIDTH-1:0]                            rd_b_i,
  output logic                                              done_o,
  output logic signed [2*COUNT_WIDTH+$clog2(BINS):0]        dot_o,
  output logic [2*COUNT_WIDTH+$clog2(BINS)-1:0]             n1_o,
  output logic [2*COUNT_WIDTH+$clog2(BINS)-1:0]             n2_o
);
  import ccs_pkg::*;

  localparam int AW = $clog2(BINS);
  localparam int DW = COUNT_WIDTH + 1;
  localparam int NW = 2*COUNT_WIDTH + AW;

  mac_state_e state_q, state_d;

  logic [AW-1:0]          j_q;
  logic [COUNT_WIDTH-1:0] prev_a_q, prev_b_q;
  logic signed [DW-1:0]   ca_q, cb_q, ca_d, cb_d, mx, my;
  logic signed [2*DW-1:0] prod_q, prod_d;
  logic [NW-1:0]          n1_q, n2_q;
  logic signed [NW:0]     dot_q;
  logic                   done_q, first, last;

  assign first = j_q == AW'(1);
  assign last  = j_q == AW'(BINS - 1);
  assign ca_d  = $signed({1'b0, rd_a_i}) - $signed({1'b0, prev_a_q});
  assign cb_d  = $signed({1'b0, rd_b_i}) - $signed({1'b0, prev_b_q});
  assign prod_d = mx * my;

  always_comb begin
    state_d = state_q;
    case (state_q)
      MS_IDLE:  if (start_i) state_d = MS_READ;
      MS_READ:  state_d = MS_DIFF;
      MS_DIFF:  state_d = first ? MS_READ : MS_SQA;
      MS_SQA:   state_d = MS_SQB;
      MS_SQB:   state_d = MS_CROSS;
      MS_CROSS: state_d = MS_ACC;
      MS_ACC:   state_d = last ? MS_IDLE : MS_READ;
      default:  state_d = MS_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      MS_SQA: begin
        mx = ca_q;
        my = ca_q;
      end
      MS_SQB: begin
        mx = cb_q;
        my = cb_q;
      end
      default: begin
        mx = ca_q;
        my = cb_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == MS_ACC) && last;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MS_IDLE: begin
        if (start_i) begin
          j_q   <= AW'(1);
          n1_q  <= '0;
          n2_q  <= '0;
          dot_q <= '0;
        end
      end
      MS_DIFF: begin
        prev_a_q <= rd_a_i;
        prev_b_q <= rd_b_i;
        ca_q     <= ca_d;
        cb_q     <= cb_d;
        if (first) begin
          j_q <= j_q + 1'b1;
        end
      end
      MS_SQA: prod_q <= prod_d;
      MS_SQB: begin
        n1_q   <= n1_q + NW'($unsigned(prod_q));
        prod_q <= prod_d;
      end
      MS_CROSS: begin
        n2_q   <= n2_q + NW'($unsigned(prod_q));
        prod_q <= prod_d;
      end
      MS_ACC: begin
        dot_q <= dot_q + (NW+1)'(prod_q);
        j_q   <= j_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign rd_addr_o = j_q;
  assign done_o    = done_q;
  assign dot_o     = dot_q;
  assign n1_o      = n1_q;
  assign n2_o      = n2_q;

endmodule

FILE: design/ccs_solve.sv
// Turns dot product and norms into the mapped similarity with one shared wide add/subtract
// unit: shift-add products, a restoring division and a digit-by-digit square root.
// Depends on ccs_pkg.
module ccs_solve #(
  parameter int BINS        = ccs_pkg::BINS_DEF,
  parameter int COUNT_WIDTH = ccs_pkg::COUNT_W_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic signed [2*COUNT_WIDTH+$clog2(BINS):0]    dot_i,
  input  logic [2*COUNT_WIDTH+$clog2(BINS)-1:0]         n1_i,
  input  logic [2*COUNT_WIDTH+$clog2(BINS)-1:0]         n2_i,
  output logic                                          done_o,
  output ccs_pkg::ccs_result_t                          result_o
);
  import ccs_pkg::*;

  localparam int NW   = 2*COUNT_WIDTH + $clog2(BINS);
  localparam int PW   = 2*NW;
  localparam int SW   = (PW + 1 > 33) ? PW + 1 : 33;
  localparam int ITER = (NW > QUO_W) ? NW : QUO_W;
  localparam int CNTW = $clog2(ITER);
  localparam int EW   = (NW + 1 > 33) ? NW + 1 : 33;
  localparam logic signed [EW-1:0] EXT_MAX = EW'(DOT_MAX);
  localparam logic signed [EW-1:0] EXT_MIN = EW'(DOT_MIN);

  solve_state_e state_q, state_d;

  logic [CNTW-1:0]      cnt_q;
  logic                 last;
  logic [PW-1:0]        acc_q, mc_q, p_q, rem_q, acc_nx, rem_nx;
  logic [NW-1:0]        mr_q, abs_dot;
  logic [NW:0]          abs_full;
  logic                 dbit_q, deg_q, done_q;
  logic [QUO_W-1:0]     q_q, q_nx;
  logic [31:0]          op_q, res_q, one_q;
  logic signed [NW:0]   dot_q;
  logic [SW-1:0]        a_op, b_op;
  logic                 sub;
  logic [SW:0]          sum;
  logic                 ge;
  logic [SIM_W-1:0]     r, m, sim;
  logic signed [EW-1:0] dot_ext;
  logic signed [DOT_W-1:0] dot_sat;
  ccs_result_t          result_q;

  assign sum = {1'b0, a_op} + ({1'b0, b_op} ^ {(SW+1){sub}}) + (SW+1)'(sub);
  assign ge  = !sum[SW];

  assign abs_full = dot_q[NW] ? -dot_q : dot_q;
  assign abs_dot  = abs_full[NW-1:0];
  assign acc_nx   = mr_q[0] ? sum[PW-1:0] : acc_q;
  assign rem_nx   = ge ? sum[PW-1:0] : {rem_q[PW-2:0], dbit_q};
  assign q_nx     = {q_q[QUO_W-2:0], ge};

  always_comb begin
    case (state_q)
      SV_MULP, SV_MULS: last = cnt_q == CNTW'(NW - 1);
      SV_DIV:           last = cnt_q == CNTW'(QUO_W - 1);
      SV_SQRT:          last = cnt_q == CNTW'(SQRT_STEPS - 1);
      default:          last = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SV_IDLE: begin
        if (start_i) begin
          state_d = (n1_i == '0 || n2_i == '0) ? SV_DONE : SV_MULP;
        end
      end
      SV_MULP: if (last) state_d = SV_MULS;
      SV_MULS: if (last) state_d = SV_DIV;
      SV_DIV:  if (last) state_d = SV_SQRT;
      SV_SQRT: if (last) state_d = SV_DONE;
      SV_DONE: state_d = SV_IDLE;
      default: state_d = SV_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      SV_MULP, SV_MULS: begin
        a_op = SW'(acc_q);
        b_op = SW'(mc_q);
        sub  = 1'b0;
      end
      SV_DIV: begin
        a_op = SW'({rem_q, dbit_q});
        b_op = SW'(p_q);
        sub  = 1'b1;
      end
      SV_SQRT: begin
        a_op = SW'(op_q);
        b_op = SW'(res_q | one_q);
        sub  = 1'b1;
      end
      default: begin
        a_op = '0;
        b_op = '0;
        sub  = 1'b0;
      end
    endcase
  end

  always_comb begin
    r = res_q[SIM_W-1:0];
    m = r + SIM_W'(op_q != '0);
    if (deg_q) begin
      sim = '0;
    end else if (dot_q[NW]) begin
      sim = (m > SIM_HALF) ? '0 : SIM_HALF - m;
    end else begin
      sim = SIM_HALF + ((r > SIM_HALF) ? SIM_HALF : r);
    end
    dot_ext = EW'(dot_q);
    if (dot_ext > EXT_MAX) begin
      dot_sat = DOT_MAX;
    end else if (dot_ext < EXT_MIN) begin
      dot_sat = DOT_MIN;
    end else begin
      dot_sat = dot_ext[DOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= state_q == SV_DONE;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SV_IDLE: begin
        if (start_i) begin
          dot_q <= dot_i;
          deg_q <= n1_i == '0 || n2_i == '0;
          acc_q <= '0;
          mc_q  <= PW'(n1_i);
          mr_q  <= n2_i;
          cnt_q <= '0;
        end
      end
      SV_MULP, SV_MULS: begin
        acc_q <= acc_nx;
        mc_q  <= mc_q << 1;
        mr_q  <= mr_q >> 1;
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          cnt_q <= '0;
          if (state_q == SV_MULP) begin
            p_q   <= acc_nx;
            acc_q <= '0;
            mc_q  <= PW'(abs_dot);
            mr_q  <= abs_dot;
          end else begin
            rem_q  <= acc_nx >> 1;
            dbit_q <= acc_nx[0];
            q_q    <= '0;
          end
        end
      end
      SV_DIV: begin
        rem_q  <= rem_nx;
        dbit_q <= 1'b0;
        q_q    <= q_nx;
        cnt_q  <= cnt_q + 1'b1;
        if (last) begin
          cnt_q <= '0;
          op_q  <= 32'(q_nx) + 32'(dot_q[NW] && rem_nx != '0);
          res_q <= '0;
          one_q <= SQRT_ONE_INIT;
        end
      end
      SV_SQRT: begin
        op_q  <= ge ? sum[31:0] : op_q;
        res_q <= ge ? ((res_q >> 1) | one_q) : (res_q >> 1);
        one_q <= one_q >> 2;
        cnt_q <= cnt_q + 1'b1;
      end
      SV_DONE: begin
        result_q.similarity  <= sim;
        result_q.degenerate  <= deg_q;
        result_q.dot_product <= dot_sat;
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

FILE: design/curvature_cosine_similarity.sv
// Spike request: accepted when idle; runs the 16-step bin-index divider, reads the bin and writes it back;
// a spike past the last bin skips the write.
// Compute request: sweeps both histograms into NW = 2*COUNT_WIDTH+clog2(BINS) bit norms, then solves,
// skipping the solve arithmetic when a norm is zero, and waits for the output register to empty.
// One request at a time; a finished result waits in an output register while new requests run.
// Reset empties both histograms at once through valid bits and sets bin_width to 256.
module curvature_cosine_similarity #(
  parameter int BINS        = ccs_pkg::BINS_DEF,
  parameter int COUNT_WIDTH = ccs_pkg::COUNT_W_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ccs_req_if.sink                       req_i,
  ccs_res_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ccs_pkg::PADDR_W-1:0]   paddr,
  input  logic [ccs_pkg::PDATA_W-1:0]   pwdata,
  output logic [ccs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import ccs_pkg::*;

  localparam int AW = $clog2(BINS);
  localparam int NW = 2*COUNT_WIDTH + AW;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  ccs_state_e state_q, state_d;

  logic [TIME_W-1:0]      bin_width_q, den, quo, idx_q;
  logic                   sel_q, tzero_q, accept, div_start, div_done;
  logic                   in_range, mac_start, mac_done, solve_start, solve_done, emit_go;
  logic [AW-1:0]          rd_addr, mac_addr;
  logic [COUNT_WIDTH-1:0] rd_a, rd_b, cur;
  logic                   wr_en, clr;
  logic signed [NW:0]     dot;
  logic [NW-1:0]          n1, n2;
  ccs_result_t            result;
  logic                   res_vld_q;
  ccs_result_t            res_q;

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_BIN_WIDTH) ? PDATA_W'(bin_width_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= BIN_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_BIN_WIDTH) begin
      bin_width_q <= pwdata[TIME_W-1:0];
    end
  end

  assign accept   = req_i.valid && req_i.ready;
  assign den      = (bin_width_q == '0) ? TIME_W'(1) : bin_width_q;
  assign in_range = idx_q < TIME_W'(BINS);
  assign cur      = sel_q ? rd_b : rd_a;
  assign rd_addr  = (state_q == ST_MAC) ? mac_addr : idx_q[AW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            REQ_SPIKE_A, REQ_SPIKE_B: state_d = ST_DIV;
            REQ_COMPUTE:              state_d = ST_MAC;
            default:                  state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV:   if (div_done) state_d = ST_RD;
      ST_RD:    state_d = in_range ? ST_WR : ST_IDLE;
      ST_WR:    state_d = ST_IDLE;
      ST_MAC:   if (mac_done) state_d = ST_SOLVE;
      ST_SOLVE: if (solve_done) state_d = ST_EMIT;
      ST_EMIT:  if (emit_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = state_q == ST_IDLE;
    div_start   = accept && (req_i.req_type == REQ_SPIKE_A || req_i.req_type == REQ_SPIKE_B);
    mac_start   = accept && req_i.req_type == REQ_COMPUTE;
    solve_start = (state_q == ST_MAC) && mac_done;
    emit_go     = (state_q == ST_EMIT) && (!res_vld_q || res_o.ready);
    wr_en       = (state_q == ST_WR) && cur != CNT_MAX;
    clr         = emit_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_go) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      sel_q   <= req_i.req_type == REQ_SPIKE_B;
      tzero_q <= req_i.spike_time == '0;
    end
    if (state_q == ST_DIV && div_done) begin
      idx_q <= tzero_q ? '0 : quo;
    end
    if (emit_go) begin
      res_q <= result;
    end
  end

  assign res_o.valid       = res_vld_q;
  assign res_o.similarity  = res_q.similarity;
  assign res_o.degenerate  = res_q.degenerate;
  assign res_o.dot_product = res_q.dot_product;

  ccs_bindiv u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (req_i.spike_time - 1'b1),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  ccs_hist #(.BINS(BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_a_o    (rd_a),
    .rd_b_o    (rd_b),
    .wr_en_i   (wr_en),
    .wr_sel_i  (sel_q),
    .wr_addr_i (idx_q[AW-1:0]),
    .wr_data_i (cur + 1'b1),
    .clr_i     (clr)
  );

  ccs_mac #(.BINS(BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mac_start),
    .rd_addr_o (mac_addr),
    .rd_a_i    (rd_a),
    .rd_b_i    (rd_b),
    .done_o    (mac_done),
    .dot_o     (dot),
    .n1_o      (n1),
    .n2_o      (n2)
  );

  ccs_solve #(.BINS(BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_solve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (solve_start),
    .dot_i    (dot),
    .n1_i     (n1),
    .n2_i     (n2),
    .done_o   (solve_done),
    .result_o (result)
  );

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.degenerate |-> res_o.similarity == '0)
    else $error("degenerate result with nonzero similarity");

  a_sim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.similarity <= 17'd65536)
    else $error("similarity above one");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> state_q == ST_IDLE && res_vld_q)
    else $error("histogram clear without a result loaded");

  a_wr_spike: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> $past(state_q) == ST_RD && in_range)
    else $error("histogram write outside a spike update");

endmodule
